/* hdl/olst_pkg.sv */
package olst_pkg;

  // Store geometry.
  localparam int LIST_DEPTH = 64;
  localparam int IDX_W      = $clog2(LIST_DEPTH);
  localparam int CNT_W      = $clog2(LIST_DEPTH + 1);

  // Field widths fixed by the item format.
  localparam int VAL_W  = 32;
  localparam int POS_W  = 7;
  localparam int CMD_W  = 2;
  localparam int STAT_W = 3;

  // Width that holds both a count and a position for comparisons.
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef logic signed [VAL_W-1:0] value_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_SEARCH = 2'd2
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_BADPOS   = 3'd2,
    ST_NORIGHT  = 3'd3,
    ST_NOTFOUND = 3'd4,
    ST_FULL     = 3'd5
  } status_t;

  // Per-cell control from the list controller.
  typedef struct packed {
    logic load;    // take the appended value
    logic shift;   // take the right neighbor's value
    logic active;  // cell lies inside the list
    logic take;    // cell holds the entry being removed
  } cell_ctrl_t;

endpackage

/* hdl/olst_cell.sv */
module olst_cell (
  input  logic                clk,
  input  olst_pkg::cell_ctrl_t ctrl,
  input  olst_pkg::value_t    in_value,
  input  olst_pkg::value_t    nb_value,
  input  olst_pkg::value_t    key,
  output olst_pkg::value_t    value,
  output logic                match,
  output olst_pkg::value_t    take_value
);
  import olst_pkg::*;

  value_t value_r;

  // Entry storage: an append writes here, a delete pulls the neighbor in.
  always_ff @(posedge clk) begin
    priority if (ctrl.load) begin
      value_r <= in_value;
    end else if (ctrl.shift) begin
      value_r <= nb_value;
    end
  end

  // Local compare and gated read for the removal path.
  assign value      = value_r;
  assign match      = ctrl.active && (value_r == key);
  assign take_value = ctrl.take ? value_r : '0;

endmodule

/* hdl/olst_pick.sv */
module olst_pick (
  input  logic [olst_pkg::LIST_DEPTH-1:0] match,
  output logic                            any,
  output logic [olst_pkg::IDX_W-1:0]      idx
);
  import olst_pkg::*;

  logic [LIST_DEPTH-1:0] lowest;

  // Isolate the lowest set match bit, then encode its index.
  assign lowest = match & (~match + {{(LIST_DEPTH-1){1'b0}}, 1'b1});
  assign any    = |match;

  always_comb begin
    idx = '0;
    for (int i = 0; i < LIST_DEPTH; i++) begin
      if (lowest[i]) begin
        idx = idx | IDX_W'(i);
      end
    end
  end

endmodule

/* hdl/ordered_list_engine.sv */
// Ordered list engine: a list of up to 64 signed 32-bit values held in a row of
// cells, one entry per cell, with an entry count.
// Input channel: in_tuser carries the command (append at rear, delete the
// entry right of a 1-based position, search for a key); in_tdata carries the
// value or key and the position.
// Output channel: one result item per command. out_tuser carries the status;
// out_tdata carries the match position, the removed or matched value and the
// entry count after the command.
// An accepted command item is registered in the middle stage and then in the
// result register, whose valid bit drives out_tvalid. One item is taken per
// cycle while the receiver does not stall: every cell compares against the key
// and shifts toward the front in the acceptance cycle, and the first-match
// encode runs in the next stage.
// When the receiver stalls, the result register holds its item, one more
// item waits in the middle stage, and in_tready drops after that.
// Reset (rst_n low, synchronous) empties the list and drops all pending
// results, and in_tready stays low while it is held; entry contents are not
// cleared and are never read before written.
module ordered_list_engine (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,   // [1:0] cmd
  input  logic [39:0] in_tdata,   // [31:0] data_value, [38:32] position, rest zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [2:0]  out_tuser,  // [2:0] status
  output logic [47:0] out_tdata   // [6:0] found_position, [38:7] result_value,
                                  // [45:39] entry_count, rest zero
);
  import olst_pkg::*;

  // Input field decode.
  cmd_t            cmd;
  value_t          in_value;
  logic [CMP_W-1:0] k_cmp;
  logic [CMP_W-1:0] cnt_cmp;

  logic             accept;
  logic             s1_adv;
  logic             full;
  logic             ins_ok;
  logic             del_ok;

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;

  // Middle stage.
  logic                  s1_valid_r;
  logic                  s1_valid_nxt;
  logic                  s1_search_r;
  logic                  s1_search_nxt;
  status_t               s1_status_r;
  status_t               s1_status_nxt;
  value_t                s1_key_r;
  value_t                s1_rval_r;
  value_t                s1_rval_nxt;
  logic [CNT_W-1:0]      s1_count_r;
  logic [LIST_DEPTH-1:0] s1_match_r;

  // Result register.
  logic             out_valid_r;
  status_t          out_status_r;
  logic [POS_W-1:0] out_fpos_r;
  value_t           out_rval_r;
  logic [POS_W-1:0] out_count_r;
  status_t          res_status;
  logic [POS_W-1:0] res_fpos;
  value_t           res_rval;
  logic [CMP_W-1:0] res_cnt;
  logic [CMP_W-1:0] pick_pos;

  // Cell row signals.
  cell_ctrl_t            cell_ctrl [LIST_DEPTH];
  value_t                cell_value [LIST_DEPTH];
  value_t                cell_take [LIST_DEPTH];
  logic [LIST_DEPTH-1:0] cell_match;
  value_t                take_or;

  logic                  pick_any;
  logic [IDX_W-1:0]      pick_idx;

  assign cmd      = cmd_t'(in_tuser);
  assign in_value = value_t'(in_tdata[31:0]);
  assign k_cmp    = CMP_W'(in_tdata[38:32]);
  assign cnt_cmp  = CMP_W'(count_r);

  // Handshake: the middle stage moves on when the result register is free.
  assign s1_adv    = !out_valid_r || out_tready;
  assign in_tready = rst_n && (!s1_valid_r || s1_adv);
  assign accept    = in_tvalid && in_tready;

  // Command checks against the current count.
  assign full   = (count_r == CNT_W'(LIST_DEPTH));
  assign ins_ok = accept && (cmd == CMD_INSERT) && !full;
  assign del_ok = accept && (cmd == CMD_DELETE) && (cnt_cmp != '0) &&
                  (k_cmp != '0) && (k_cmp < cnt_cmp);

  // Row of cells; each cell's right neighbor feeds it on a delete.
  for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
    localparam logic [CMP_W-1:0] IDX  = CMP_W'(i);
    localparam logic [CMP_W-1:0] IDX1 = CMP_W'(i + 1);
    value_t nb;

    if (i == LIST_DEPTH - 1) begin : g_last
      assign nb = '0;
    end else begin : g_mid
      assign nb = cell_value[i+1];
    end

    assign cell_ctrl[i].load   = ins_ok && (cnt_cmp == IDX);
    assign cell_ctrl[i].shift  = del_ok && (IDX >= k_cmp) && (IDX1 < cnt_cmp);
    assign cell_ctrl[i].active = (IDX < cnt_cmp);
    assign cell_ctrl[i].take   = del_ok && (IDX == k_cmp);

    olst_cell u_cell (
      .clk        (clk),
      .ctrl       (cell_ctrl[i]),
      .in_value   (in_value),
      .nb_value   (nb),
      .key        (in_value),
      .value      (cell_value[i]),
      .match      (cell_match[i]),
      .take_value (cell_take[i])
    );
  end

  // Collect the removed value; at most one cell drives it.
  always_comb begin
    take_or = '0;
    for (int i = 0; i < LIST_DEPTH; i++) begin
      take_or = take_or | cell_take[i];
    end
  end

  // Status, count and removed value of the accepted item.
  always_comb begin
    s1_status_nxt = ST_OK;
    s1_search_nxt = 1'b0;
    unique case (cmd)
      CMD_INSERT: begin
        s1_status_nxt = full ? ST_FULL : ST_OK;
      end
      CMD_DELETE: begin
        priority if (cnt_cmp == '0) begin
          s1_status_nxt = ST_EMPTY;
        end else if ((k_cmp == '0) || (k_cmp > cnt_cmp)) begin
          s1_status_nxt = ST_BADPOS;
        end else if (k_cmp == cnt_cmp) begin
          s1_status_nxt = ST_NORIGHT;
        end else begin
          s1_status_nxt = ST_OK;
        end
      end
      CMD_SEARCH: begin
        if (cnt_cmp == '0) begin
          s1_status_nxt = ST_EMPTY;
        end else begin
          s1_status_nxt = ST_NOTFOUND;
          s1_search_nxt = 1'b1;
        end
      end
      default: begin
        s1_status_nxt = ST_OK;
      end
    endcase

    priority if (ins_ok) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (del_ok) begin
      count_nxt = count_r - CNT_W'(1);
    end else begin
      count_nxt = count_r;
    end

    s1_rval_nxt = del_ok ? take_or : '0;

    priority if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  // Count and middle stage registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      count_r    <= count_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
    if (accept) begin
      s1_status_r <= s1_status_nxt;
      s1_search_r <= s1_search_nxt;
      s1_key_r    <= in_value;
      s1_rval_r   <= s1_rval_nxt;
      s1_count_r  <= count_nxt;
      s1_match_r  <= cell_match;
    end
  end

  // First match among the registered compare bits.
  olst_pick u_pick (
    .match (s1_match_r),
    .any   (pick_any),
    .idx   (pick_idx)
  );

  // Final result fields.
  always_comb begin
    pick_pos   = CMP_W'(pick_idx) + CMP_W'(1);
    res_cnt    = CMP_W'(s1_count_r);
    res_status = s1_status_r;
    res_fpos   = '0;
    res_rval   = s1_rval_r;
    if (s1_search_r && pick_any) begin
      res_status = ST_OK;
      res_fpos   = pick_pos[POS_W-1:0];
      res_rval   = s1_key_r;
    end
  end

  // Result register; it holds its item while the receiver stalls.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_valid_r;
    end
    if (s1_adv && s1_valid_r) begin
      out_status_r <= res_status;
      out_fpos_r   <= res_fpos;
      out_rval_r   <= res_rval;
      out_count_r  <= res_cnt[POS_W-1:0];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {2'b00, out_count_r, out_rval_r, out_fpos_r};

endmodule

/* tb/sv/ordered_list_engine_tb.sv */
module ordered_list_engine_tb;
  import olst_pkg::*;

  // The one command code the block ignores.
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  // Cycles with no item moving on either channel before the run is abandoned.
  localparam int STALL_LIMIT = 1000;
  // Long receiver hold-off used to fill the pipeline and stall the input.
  localparam int LONG_HOLD = 60;

  typedef struct {
    status_t          status;
    logic [POS_W-1:0] found_pos;
    value_t           value;
    logic [POS_W-1:0] count;
  } list_reply_t;

  // Shadow copy of the list plus the queue of replies still owed by the block.
  class olist_scoreboard;
    value_t      shadow_slots[LIST_DEPTH];
    int          shadow_count;
    list_reply_t pending_replies[$];
    int          errors;

    function new();
      shadow_count = 0;
      errors = 0;
    endfunction

    function int pending();
      return pending_replies.size();
    endfunction

    // Apply one accepted command to the shadow list and queue its reply.
    function void note_command(logic [CMD_W-1:0] op, value_t key, logic [POS_W-1:0] k);
      list_reply_t r;
      int          pos;
      int          i;
      r.status = ST_OK;
      r.found_pos = '0;
      r.value = '0;
      pos = k;
      case (op)
        CMD_INSERT: begin
          if (shadow_count >= LIST_DEPTH) begin
            r.status = ST_FULL;
          end else begin
            shadow_slots[shadow_count] = key;
            shadow_count++;
          end
        end
        CMD_DELETE: begin
          if (shadow_count == 0) begin
            r.status = ST_EMPTY;
          end else if (pos < 1 || pos > shadow_count) begin
            r.status = ST_BADPOS;
          end else if (pos == shadow_count) begin
            r.status = ST_NORIGHT;
          end else begin
            // The right neighbor of 1-based position k sits at index k.
            r.value = shadow_slots[pos];
            for (i = pos; i + 1 < shadow_count; i++)
              shadow_slots[i] = shadow_slots[i + 1];
            shadow_count--;
          end
        end
        CMD_SEARCH: begin
          if (shadow_count == 0) begin
            r.status = ST_EMPTY;
          end else begin
            r.status = ST_NOTFOUND;
            for (i = 0; i < shadow_count; i++) begin
              if (shadow_slots[i] == key) begin
                r.status = ST_OK;
                r.found_pos = POS_W'(i + 1);
                r.value = shadow_slots[i];
                break;
              end
            end
          end
        end
        default: begin
          // Unused code: nothing changes and only the count is reported.
        end
      endcase
      r.count = POS_W'(shadow_count);
      pending_replies.push_back(r);
    endfunction

    // Compare one accepted result item with the oldest owed reply.
    function void check_result(logic [STAT_W-1:0] st, logic [47:0] td);
      list_reply_t want;
      if (pending_replies.size() == 0) begin
        $error("result item with no command outstanding: status %0d", st);
        errors++;
        return;
      end
      want = pending_replies.pop_front();
      if (st !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, st);
        errors++;
      end
      if (td[6:0] !== want.found_pos) begin
        $error("found_position: expected %0d, actual %0d", want.found_pos, td[6:0]);
        errors++;
      end
      if (td[38:7] !== want.value) begin
        $error("result_value: expected %0d, actual %0d", want.value, $signed(td[38:7]));
        errors++;
      end
      if (td[45:39] !== want.count) begin
        $error("entry_count: expected %0d, actual %0d", want.count, td[45:39]);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [1:0]  in_tuser;
  logic [39:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [2:0]  out_tuser;
  logic [47:0] out_tdata;

  olist_scoreboard sb = new();

  // Traffic shaping for the sender and the receiver, and the watchdog's idle count.
  bit calm;
  bit hold_request;
  int steady_items;
  int idle_cycles;

  ordered_list_engine dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata)
  );

  // Clock with a period of 10.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tuser = '0;
    in_tdata = '0;
    out_tready = 1'b0;
    calm = 1'b0;
    hold_request = 1'b0;
    steady_items = 0;
  end

  // Receiver: random ready bursts, one long hold-off on request, always ready when calm.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_tready <= 1'b0;
        repeat (LONG_HOLD - 1) @(posedge clk);
      end else if (calm) begin
        out_tready <= 1'b1;
      end else if ($urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(0, 15)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(0, 15)) @(posedge clk);
      end
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(out_tuser, out_tdata);
  end

  // Watchdog on cycles in which no item moves.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // Optional idle burst on the input side between items.
  task automatic sender_gap();
    if (steady_items > 0) begin
      steady_items--;
    end else if (!calm && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  // Present one command and hold it until the block takes it.
  task automatic offer_command(input logic [CMD_W-1:0] op, input value_t val,
                               input logic [POS_W-1:0] k);
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {1'b0, k, val};
    do @(posedge clk); while (!in_tready);
    sb.note_command(op, val, k);
    sender_gap();
  endtask

  // Values lean toward a small pool so that duplicates and search hits occur.
  function automatic value_t pick_value();
    int r;
    r = $urandom_range(0, 19);
    if (r < 5) return value_t'(int'($urandom_range(0, 4)) - 2);
    if (r == 5) return value_t'(32'h8000_0000);
    if (r == 6) return value_t'(32'h7fff_ffff);
    return value_t'($urandom);
  endfunction

  // One random command, weighted by the given insert and delete shares.
  task automatic random_item(input int ins_pct, input int del_pct);
    int               roll;
    int               cnt;
    int               r;
    logic [CMD_W-1:0] op;
    value_t           v;
    logic [POS_W-1:0] k;
    cnt = sb.shadow_count;
    roll = $urandom_range(0, 99);
    v = pick_value();
    k = POS_W'($urandom_range(0, LIST_DEPTH));
    if (roll < 3) begin
      op = CMD_UNUSED;
    end else if (roll < 3 + ins_pct) begin
      op = CMD_INSERT;
    end else if (roll < 3 + ins_pct + del_pct) begin
      op = CMD_DELETE;
      // Mostly a position with a right neighbor, sometimes an edge or bad one.
      r = $urandom_range(0, 9);
      if (cnt >= 2 && r < 7)
        k = POS_W'($urandom_range(1, cnt - 1));
      else if (r == 7)
        k = POS_W'(cnt);
      else if (r == 8)
        k = (cnt < LIST_DEPTH) ? POS_W'(cnt + 1) : '0;
    end else begin
      op = CMD_SEARCH;
      if (cnt > 0 && $urandom_range(0, 1) == 1)
        v = sb.shadow_slots[$urandom_range(0, cnt - 1)];
    end
    offer_command(op, v, k);
  endtask

  task automatic run_phase(input int items, input int ins_pct, input int del_pct);
    repeat (items) random_item(ins_pct, del_pct);
  endtask

  // Lower valid and wait until every owed reply has arrived.
  task automatic drain_replies();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Main sequence.
  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty list, extremes, every status but full, duplicates, unused code.
    offer_command(CMD_DELETE, value_t'(0), 7'd1);
    offer_command(CMD_SEARCH, value_t'(5), 7'd0);
    offer_command(CMD_UNUSED, value_t'(32'hffff_ffff), 7'd127);
    offer_command(CMD_INSERT, value_t'(32'h8000_0000), 7'd0);
    offer_command(CMD_INSERT, value_t'(32'h7fff_ffff), 7'd64);
    offer_command(CMD_INSERT, value_t'(0), 7'd0);
    offer_command(CMD_INSERT, value_t'(-1), 7'd0);
    offer_command(CMD_SEARCH, value_t'(32'h7fff_ffff), 7'd0);
    offer_command(CMD_SEARCH, value_t'(32'h8000_0000), 7'd0);
    offer_command(CMD_SEARCH, value_t'(12345), 7'd0);
    offer_command(CMD_DELETE, value_t'(0), 7'd0);
    offer_command(CMD_DELETE, value_t'(0), 7'd5);
    offer_command(CMD_DELETE, value_t'(0), 7'd64);
    offer_command(CMD_DELETE, value_t'(0), 7'd4);
    offer_command(CMD_DELETE, value_t'(0), 7'd1);
    offer_command(CMD_INSERT, value_t'(0), 7'd0);
    offer_command(CMD_SEARCH, value_t'(0), 7'd0);
    offer_command(CMD_SEARCH, value_t'(-1), 7'd0);
    offer_command(CMD_UNUSED, value_t'(7), 7'd3);
    offer_command(CMD_DELETE, value_t'(0), 7'd3);
    offer_command(CMD_DELETE, value_t'(0), 7'd1);

    // Mixed traffic.
    run_phase(60, 40, 30);

    // Fill to capacity while the receiver holds off and the sender keeps offering.
    hold_request = 1'b1;
    steady_items = 40;
    run_phase(100, 85, 10);

    // Pause until the block is empty of work, then drain the list.
    drain_replies();
    run_phase(100, 15, 65);
    run_phase(80, 70, 15);

    // Last stretch with no idling on either side.
    calm = 1'b1;
    run_phase(60, 40, 30);

    drain_replies();
    repeat (8) @(posedge clk);
    if (sb.errors == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

/* ordered_list_engine.f */
hdl/olst_pkg.sv
hdl/olst_cell.sv
hdl/olst_pick.sv
hdl/ordered_list_engine.sv
tb/sv/ordered_list_engine_tb.sv
